>>> hdl/mcs_pkg.sv
// Shared types, codes and reset values of the modem command sequencer.
`timescale 1ns / 1ps

package mcs_pkg;

  // Input action codes
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_POLL = 2'd2;

  // Classified item kinds carried through the command queue
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  // Sequence steps
  localparam logic [2:0] STEP_RESET   = 3'd0;
  localparam logic [2:0] STEP_JOIN    = 3'd1;
  localparam logic [2:0] STEP_ADDR    = 3'd2;
  localparam logic [2:0] STEP_CONNECT = 3'd3;
  localparam logic [2:0] STEP_SEND0   = 3'd4;
  localparam logic [2:0] STEP_SEND2   = 3'd6;
  localparam logic [2:0] STEP_SEND3   = 3'd7;

  // Reply check kinds
  localparam logic [1:0] EXP_ANY    = 2'd0;
  localparam logic [1:0] EXP_OK     = 2'd1;
  localparam logic [1:0] EXP_PROMPT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SHORT_WAIT  = 3'd0;
  localparam logic [2:0] REG_LONG_WAIT   = 3'd1;
  localparam logic [2:0] REG_OK_WORD     = 3'd2;
  localparam logic [2:0] REG_PROMPT_WORD = 3'd3;
  localparam logic [2:0] REG_RETRY_LIM   = 3'd4;
  localparam logic [2:0] REG_TOTAL_LIM   = 3'd5;

  // Configuration reset values
  localparam logic [21:0] RST_SHORT_WAIT  = 22'd300000;
  localparam logic [21:0] RST_LONG_WAIT   = 22'd500000;
  localparam logic [31:0] RST_OK_WORD     = 32'h4F4B0D0A;
  localparam logic [47:0] RST_PROMPT_WORD = 48'h4F4B0D0A3E20;
  localparam logic [3:0]  RST_RETRY_LIM   = 4'd5;
  localparam logic [7:0]  RST_TOTAL_LIM   = 8'd10;

  localparam logic [22:0] ELAPSED_MAX = 23'h7FFFFF;

  // Default sizes
  localparam int HISTORY_BYTES_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Item handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [2:0]         command_id;
    logic signed [15:0] payload_value;
  } res_t;

endpackage

>>> hdl/modem_command_sequencer.sv
// Top level of the modem command sequencer: front, command queue, back and result queue.
`timescale 1ns / 1ps

// Takes one item per clock while in_full is low: a received byte, a timer
// tick or a poll. Each transfer is decoded by the front, and each known one
// lands in a QUEUE_DEPTH-entry command queue; the back retires one queued
// item per cycle while the result queue is not full, in a single step of its
// sequencer logic, and pushes any command it issues into a QUEUE_DEPTH-entry
// result queue. A command issued for an item is registered in the command
// queue and then in the result queue before it is on the out_ ports. The
// sustained rate is one item per cycle while the result queue has room; input
// stalls only when the result queue stays full long enough to back up the command queue.
module modem_command_sequencer
  import mcs_pkg::*;
#(
  parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic signed [15:0] in_sample_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_command_id,
  output logic signed [15:0] out_payload_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  cmd_t q_item, cmd_item;
  res_t res_item, out_item;
  logic q_push, q_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  mcs_front u_front (
    .in_push         (in_push),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .in_sample_value (in_sample_value),
    .in_full         (in_full),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  mcs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_item),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_item),
    .empty     (cmd_empty)
  );

  mcs_back #(
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_item  (cmd_item),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  mcs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_item),
    .empty     (out_empty)
  );

  assign out_command_id    = out_item.command_id;
  assign out_payload_value = out_item.payload_value;

`ifndef SYNTHESIS
  // The back never issues into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result pushed into full queue");

  // The back only retires an item that is present
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // Only the two last send phases carry a value
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_command_id < STEP_SEND2) |-> (out_payload_value == 16'sd0))
    else $error("payload on a command without value");
`endif

endmodule

>>> hdl/mcs_fifo.sv
// Small register FIFO used for the command queue and the result queue.
`timescale 1ns / 1ps

module mcs_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/mcs_front.sv
// Input front: decodes the action of each transfer and queues the work for the back.
`timescale 1ns / 1ps

module mcs_front
  import mcs_pkg::*;
(
  input  logic        in_push,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic signed [15:0] in_sample_value,
  output logic        in_full,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_item
);

  logic known;

  assign in_full = q_full;

  // Classify: bytes carry the received byte, polls carry the sample,
  // ticks carry nothing; an unused action is taken and dropped here.
  always_comb begin
    known       = 1'b1;
    q_item.kind = KIND_TICK;
    q_item.data = '0;
    case (in_action)
      ACT_BYTE: begin
        q_item.kind = KIND_BYTE;
        q_item.data = {8'h00, in_rx_byte};
      end
      ACT_TICK: begin
        q_item.kind = KIND_TICK;
      end
      ACT_POLL: begin
        q_item.kind = KIND_POLL;
        q_item.data = in_sample_value;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign q_push = in_push && !q_full && known;

endmodule

>>> hdl/mcs_back.sv
// Sequencer back end: reply history, wait timer, step logic and configuration registers.
`timescale 1ns / 1ps

module mcs_back
  import mcs_pkg::*;
#(
  parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  cmd_t        cmd_item,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  logic        res_full,
  output logic        res_push,
  output res_t        res_item
);

  // Configuration
  logic [21:0] short_wait_r, long_wait_r;
  logic [31:0] ok_word_r;
  logic [47:0] prompt_word_r;
  logic [3:0]  retry_lim_r;
  logic [7:0]  total_lim_r;

  // Sequencer state
  logic [2:0]  step_r, step_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  hist_r [HISTORY_BYTES];
  logic [7:0]  hist_nxt [HISTORY_BYTES];
  logic [22:0] elapsed_r, elapsed_nxt;
  logic [21:0] wlim_r, wlim_nxt;
  logic [1:0]  exp_r, exp_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [7:0]  toterr_r, toterr_nxt;
  logic signed [15:0] held_r, held_nxt;

  logic [7:0]  hist_ext [6];
  logic        match;
  logic        wait_over;
  logic        do_issue;
  logic [2:0]  iss_step;
  logic [4:0]  retry_inc;
  logic [7:0]  toterr_inc;

  // Bytes beyond the history depth read as zero
  for (genvar g = 0; g < 6; g++) begin : g_ext
    if (g < HISTORY_BYTES) begin : g_have
      assign hist_ext[g] = hist_r[g];
    end else begin : g_zero
      assign hist_ext[g] = 8'h00;
    end
  end

  // Reply check against the expected suffix, newest byte in the low slot
  always_comb begin
    case (exp_r)
      EXP_OK: begin
        match = ({hist_ext[3], hist_ext[2], hist_ext[1], hist_ext[0]} == ok_word_r);
      end
      EXP_PROMPT: begin
        match = ({hist_ext[5], hist_ext[4], hist_ext[3], hist_ext[2],
                  hist_ext[1], hist_ext[0]} == prompt_word_r);
      end
      default: begin
        match = 1'b1;
      end
    endcase
  end

  assign wait_over  = (elapsed_r >= {1'b0, wlim_r});
  assign cmd_pop    = !cmd_empty && !res_full;
  assign retry_inc  = {1'b0, retry_r} + 5'd1;
  assign toterr_inc = (toterr_r == 8'hFF) ? toterr_r : toterr_r + 8'd1;

  // Step logic for the item at the head of the queue
  always_comb begin
    step_nxt    = step_r;
    await_nxt   = await_r;
    hist_nxt    = hist_r;
    elapsed_nxt = elapsed_r;
    wlim_nxt    = wlim_r;
    exp_nxt     = exp_r;
    retry_nxt   = retry_r;
    toterr_nxt  = toterr_r;
    held_nxt    = held_r;
    do_issue    = 1'b0;
    iss_step    = step_r;
    res_item    = '0;

    if (cmd_pop) begin
      case (cmd_item.kind)
        KIND_BYTE: begin
          for (int i = HISTORY_BYTES - 1; i > 0; i--) begin
            hist_nxt[i] = hist_r[i-1];
          end
          hist_nxt[0] = cmd_item.data[7:0];
        end
        KIND_TICK: begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 23'd1;
          end
        end
        KIND_POLL: begin
          if (wait_over) begin
            if (!await_r) begin
              do_issue = 1'b1;
            end else begin
              hist_nxt  = '{default: 8'h00};
              await_nxt = 1'b0;
              if (match) begin
                if (step_r == STEP_SEND3) begin
                  step_nxt = STEP_SEND0;
                end else begin
                  do_issue = 1'b1;
                  iss_step = step_r + 3'd1;
                end
              end else if (step_r == STEP_SEND3) begin
                step_nxt = STEP_CONNECT;
              end else if (step_r != STEP_RESET) begin
                // Counted failure: fall back on either limit, else retry
                toterr_nxt = toterr_inc;
                if (toterr_inc > total_lim_r) begin
                  retry_nxt = retry_inc[4] ? 4'hF : retry_inc[3:0];
                  step_nxt  = (step_r <= STEP_CONNECT) ? STEP_RESET : STEP_CONNECT;
                end else if (retry_inc > {1'b0, retry_lim_r}) begin
                  retry_nxt = '0;
                  step_nxt  = (step_r <= STEP_CONNECT) ? STEP_RESET : STEP_CONNECT;
                end else begin
                  retry_nxt = retry_inc[3:0];
                  do_issue  = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Command issue: latch the value, set reply check and wait
      if (do_issue) begin
        if (iss_step == STEP_SEND2) begin
          held_nxt = cmd_item.data;
        end
        res_item.command_id    = iss_step;
        res_item.payload_value = (iss_step >= STEP_SEND2) ? held_nxt : 16'sd0;
        if (iss_step == STEP_RESET) begin
          exp_nxt = EXP_ANY;
        end else if (iss_step == STEP_SEND0 || iss_step == STEP_SEND2) begin
          exp_nxt = EXP_PROMPT;
        end else begin
          exp_nxt = EXP_OK;
        end
        wlim_nxt    = (iss_step == STEP_JOIN || iss_step == STEP_ADDR) ?
                      long_wait_r : short_wait_r;
        elapsed_nxt = '0;
        await_nxt   = 1'b1;
        step_nxt    = iss_step;
      end
    end
  end

  assign res_push = do_issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      await_r  <= 1'b0;
      hist_r   <= '{default: 8'h00};
      elapsed_r <= '0;
      wlim_r   <= '0;
      exp_r    <= EXP_ANY;
      retry_r  <= '0;
      toterr_r <= '0;
      held_r   <= '0;
    end else begin
      step_r   <= step_nxt;
      await_r  <= await_nxt;
      hist_r   <= hist_nxt;
      elapsed_r <= elapsed_nxt;
      wlim_r   <= wlim_nxt;
      exp_r    <= exp_nxt;
      retry_r  <= retry_nxt;
      toterr_r <= toterr_nxt;
      held_r   <= held_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_wait_r  <= RST_SHORT_WAIT;
      long_wait_r   <= RST_LONG_WAIT;
      ok_word_r     <= RST_OK_WORD;
      prompt_word_r <= RST_PROMPT_WORD;
      retry_lim_r   <= RST_RETRY_LIM;
      total_lim_r   <= RST_TOTAL_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_WAIT:  short_wait_r  <= cfg_wdata[21:0];
        REG_LONG_WAIT:   long_wait_r   <= cfg_wdata[21:0];
        REG_OK_WORD:     ok_word_r     <= cfg_wdata[31:0];
        REG_PROMPT_WORD: prompt_word_r <= cfg_wdata;
        REG_RETRY_LIM:   retry_lim_r   <= cfg_wdata[3:0];
        REG_TOTAL_LIM:   total_lim_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule
